[hw/rtl/bollinger_band_signal_trader_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Bollinger band trader
// Overlapping-implication and next-cycle forms, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef BOLLINGER_BAND_SIGNAL_TRADER_MACROS_SVH
`define BOLLINGER_BAND_SIGNAL_TRADER_MACROS_SVH

// check cons in the cycle where ante holds
`define BBST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbst: check failed");

// check cons in the cycle after ante holds
`define BBST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbst: check failed");

`endif

[hw/rtl/bbst_pkg.sv]
// ----------------------------------------------------------------------------
// bbst_pkg
// Codes, field widths and output packing for the Bollinger band trader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbst_pkg;

  localparam int CFG_W = 32;
  localparam int RET_W = 32;
  localparam int CNT_W = 32;
  localparam int PCT_W = 23;
  localparam int AVG_W = 48;
  localparam int FRAC_BITS = 16;
  localparam int PCT_SCALE = 100;
  localparam int TOTALS_NUM_W = 55;

  localparam int BS_LSB = 0;
  localparam int TC_BIT = 2;
  localparam int TR_LSB = 3;
  localparam int TP_BIT = 35;
  localparam int TT_LSB = 36;
  localparam int PP_LSB = 68;
  localparam int AR_LSB = 91;
  localparam int OUT_FIELDS_W = 139;
  localparam int OUT_W = 144;

  localparam logic [1:0] POS_FLAT = 2'd0;
  localparam logic [1:0] POS_LONG = 2'd1;
  localparam logic [1:0] POS_SHORT = 2'd2;

  localparam logic [1:0] SIG_NONE = 2'b00;
  localparam logic [1:0] SIG_BUY = 2'b01;
  localparam logic [1:0] SIG_SELL = 2'b11;

  localparam logic REG_THRESHOLD = 1'b0;

  localparam logic [RET_W-1:0] RET_MAX = 32'h7FFF_FFFF;
  localparam logic [RET_W-1:0] RET_MIN = 32'h8000_0000;
  localparam logic [AVG_W-1:0] AVG_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [AVG_W-1:0] AVG_MIN = 48'h8000_0000_0000;

endpackage

[hw/rtl/bollinger_band_signal_trader.sv]
// ----------------------------------------------------------------------------
// bollinger_band_signal_trader
// One item at a time: the squarings and the divides run
//   bit-serially through one shared adder (multiply by shift-add, divide by
//   restoring steps). Synchronous active-high reset clears window, trade
//   state and threshold; the last item clears all but the threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bollinger_band_signal_trader_macros.svh"

module bollinger_band_signal_trader
  import bbst_pkg::*;
#(
  parameter int WINDOW_LENGTH = 20,
  parameter int PRICE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [CFG_W-1:0]                     pwdata,
  output logic [CFG_W-1:0]                     prdata,
  output logic                                 pready,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // close_price
  input  logic [((PRICE_BITS+7)/8)*8-1:0]      s_tdata,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // band_signal, trade_closed, trade_return, trade_profitable, trade count,
  // profitable_percent, average_return_percent
  output logic [OUT_W-1:0]                     m_tdata,
  output logic                                 m_tlast
);

  localparam int N = WINDOW_LENGTH;
  localparam int PB = PRICE_BITS;
  localparam int NB = $clog2(N + 1);
  localparam int PTW = (N > 1) ? $clog2(N) : 1;
  localparam int SW = PB + NB;
  localparam int QW = 2 * PB + NB;
  localparam int PW = 2 * SW;
  localparam int DW = (PB > CNT_W) ? PB : CNT_W;
  localparam int DNW = (PB + FRAC_BITS > TOTALS_NUM_W) ? PB + FRAC_BITS : TOTALS_NUM_W;
  localparam int MAXW = (SW > DNW) ? SW : DNW;
  localparam int CW = $clog2(MAXW + 1);
  localparam int AW = ((SW > DW) ? SW : DW) + 1;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MUL_OLD = 4'd1;
  localparam logic [3:0] ST_MUL_NEW = 4'd2;
  localparam logic [3:0] ST_MUL_SS  = 4'd3;
  localparam logic [3:0] ST_MUL_DD  = 4'd4;
  localparam logic [3:0] ST_TRADE   = 4'd5;
  localparam logic [3:0] ST_DIV_RET = 4'd6;
  localparam logic [3:0] ST_CLOSE   = 4'd7;
  localparam logic [3:0] ST_TOTALS  = 4'd8;
  localparam logic [3:0] ST_DIV_PCT = 4'd9;
  localparam logic [3:0] ST_DIV_AVG = 4'd10;
  localparam logic [3:0] ST_OUT     = 4'd11;

  logic [3:0]        state;
  logic [PB-1:0]     win [N];
  logic [PTW-1:0]    ptr;
  logic [NB-1:0]     seen;
  logic [SW-1:0]     wsum;
  logic [QW-1:0]     qsum;
  logic [1:0]        pos;
  logic [PB-1:0]     entry;
  logic [CNT_W-1:0]  tcount;
  logic [CNT_W-1:0]  pcount;
  logic [AVG_W-1:0]  rsum;
  logic [CFG_W-1:0]  thr;

  logic [PB-1:0]     cur_c;
  logic              cur_last;
  logic              warm;
  logic [SW-1:0]     opa;
  logic [SW-1:0]     mhi;
  logic [SW-1:0]     mlo;
  logic [DW-1:0]     rem;
  logic [DNW-1:0]    num;
  logic [DW-1:0]     den;
  logic [CW-1:0]     cnt;
  logic [PW-1:0]     vreg;
  logic              adnz;
  logic              ngt;
  logic [1:0]        sig;
  logic              closed;
  logic [RET_W-1:0]  ret;
  logic              good;
  logic              gpos;
  logic [PCT_W-1:0]  pct;
  logic [AVG_W-1:0]  avg;

  logic [PB-1:0]     in_c;
  logic [PB-1:0]     old;
  logic [PTW-1:0]    ptr_next;
  logic              is_div;
  logic [AW-1:0]     add_x;
  logic [AW-1:0]     add_y;
  logic [AW:0]       add_full;
  logic              qbit;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     nq;
  logic [SW-1:0]     nc;
  logic [SW-1:0]     ad;
  logic              band_hit;
  logic [PB-1:0]     eff_e;
  logic [1:0]        eff_pos;
  logic              closing;
  logic              do_close;
  logic              up;
  logic [PB-1:0]     mag;
  logic              gpos_c;
  logic [AVG_W:0]    rs_ext;
  logic [AVG_W-1:0]  rs_sat;
  logic [38:0]       p100;
  logic [AVG_W-1:0]  abs_rs;
  logic [DNW-1:0]    r100;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? thr : '0;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD);
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    in_c = s_tdata[PB-1:0];
    old = win[ptr];
    ptr_next = (ptr == PTW'(N - 1)) ? '0 : ptr + 1'b1;
    is_div = (state == ST_DIV_RET) || (state == ST_DIV_PCT) || (state == ST_DIV_AVG);
    if (is_div) begin
      add_x = AW'({rem, num[DNW-1]});
      add_y = ~AW'(den);
    end else begin
      add_x = AW'(mhi);
      add_y = mlo[0] ? AW'(opa) : '0;
    end
    add_full = {1'b0, add_x} + {1'b0, add_y} + (AW + 1)'(is_div);
    qbit = add_full[AW];
    prod = {mhi, mlo};
    nq = PW'(qsum) * PW'(N);
    nc = SW'(cur_c) * SW'(N);
    ad = (nc >= wsum) ? nc - wsum : wsum - nc;
    band_hit = adnz && ({2'b00, prod} > {vreg, 2'b00});

    eff_e = (pos == POS_FLAT) ? cur_c : entry;
    if (pos == POS_FLAT) begin
      eff_pos = (sig == SIG_BUY) ? POS_LONG : POS_SHORT;
    end else begin
      eff_pos = pos;
    end
    closing = ((pos == POS_LONG) && (sig == SIG_SELL)) ||
              ((pos == POS_SHORT) && (sig == SIG_BUY));
    do_close = closing || (cur_last && ((pos != POS_FLAT) || (sig != SIG_NONE)));
    up = (cur_c >= eff_e);
    mag = up ? cur_c - eff_e : eff_e - cur_c;
    gpos_c = (eff_pos == POS_LONG) ? up : !up;

    rs_ext = {rsum[AVG_W-1], rsum} + {{(AVG_W + 1 - RET_W){ret[RET_W-1]}}, ret};
    unique case (rs_ext[AVG_W:AVG_W-1])
      2'b01:   rs_sat = AVG_MAX;
      2'b10:   rs_sat = AVG_MIN;
      default: rs_sat = rs_ext[AVG_W-1:0];
    endcase
    p100 = 39'(pcount) * 39'(PCT_SCALE);
    abs_rs = rsum[AVG_W-1] ? -rsum : rsum;
    r100 = DNW'(abs_rs) * DNW'(PCT_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < N; i++) win[i] <= '0;
      ptr <= '0;
      seen <= '0;
      wsum <= '0;
      qsum <= '0;
      pos <= POS_FLAT;
      entry <= '0;
      tcount <= '0;
      pcount <= '0;
      rsum <= '0;
      thr <= '0;
      cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) thr <= pwdata;
      if (m_tvalid && m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_c <= in_c;
            cur_last <= s_tlast;
            warm <= (seen == NB'(N));
            win[ptr] <= in_c;
            ptr <= ptr_next;
            if (seen != NB'(N)) seen <= seen + 1'b1;
            wsum <= wsum - SW'(old) + SW'(in_c);
            opa <= SW'(old);
            mhi <= '0;
            mlo <= SW'(old);
            cnt <= CW'(SW);
            sig <= SIG_NONE;
            closed <= 1'b0;
            ret <= '0;
            good <= 1'b0;
            pct <= '0;
            avg <= '0;
            state <= ST_MUL_OLD;
          end
        end
        ST_MUL_OLD: begin
          if (cnt != '0) begin
            mhi <= add_full[SW:1];
            mlo <= {add_full[0], mlo[SW-1:1]};
            cnt <= cnt - 1'b1;
          end else begin
            qsum <= qsum - prod[QW-1:0];
            opa <= SW'(cur_c);
            mhi <= '0;
            mlo <= SW'(cur_c);
            cnt <= CW'(SW);
            state <= ST_MUL_NEW;
          end
        end
        ST_MUL_NEW: begin
          if (cnt != '0) begin
            mhi <= add_full[SW:1];
            mlo <= {add_full[0], mlo[SW-1:1]};
            cnt <= cnt - 1'b1;
          end else begin
            qsum <= qsum + prod[QW-1:0];
            if (warm) begin
              opa <= wsum;
              mhi <= '0;
              mlo <= wsum;
              cnt <= CW'(SW);
              state <= ST_MUL_SS;
            end else begin
              state <= ST_TRADE;
            end
          end
        end
        ST_MUL_SS: begin
          if (cnt != '0) begin
            mhi <= add_full[SW:1];
            mlo <= {add_full[0], mlo[SW-1:1]};
            cnt <= cnt - 1'b1;
          end else begin
            vreg <= nq - prod;
            adnz <= (ad != '0);
            ngt <= (nc > wsum);
            opa <= ad;
            mhi <= '0;
            mlo <= ad;
            cnt <= CW'(SW);
            state <= ST_MUL_DD;
          end
        end
        ST_MUL_DD: begin
          if (cnt != '0) begin
            mhi <= add_full[SW:1];
            mlo <= {add_full[0], mlo[SW-1:1]};
            cnt <= cnt - 1'b1;
          end else begin
            if (band_hit) sig <= ngt ? SIG_SELL : SIG_BUY;
            state <= ST_TRADE;
          end
        end
        ST_TRADE: begin
          if ((pos == POS_FLAT) && (sig != SIG_NONE)) begin
            pos <= eff_pos;
            entry <= cur_c;
          end
          gpos <= gpos_c;
          if (do_close) begin
            if (mag == '0) begin
              ret <= '0;
              state <= ST_CLOSE;
            end else if (eff_e == '0) begin
              ret <= gpos_c ? RET_MAX : RET_MIN;
              state <= ST_CLOSE;
            end else begin
              rem <= '0;
              num <= DNW'(mag) << FRAC_BITS;
              den <= DW'(eff_e);
              cnt <= CW'(DNW);
              state <= ST_DIV_RET;
            end
          end else begin
            state <= cur_last ? ST_TOTALS : ST_OUT;
          end
        end
        ST_DIV_RET: begin
          if (cnt != '0) begin
            rem <= qbit ? add_full[DW-1:0] : add_x[DW-1:0];
            num <= {num[DNW-2:0], qbit};
            cnt <= cnt - 1'b1;
          end else begin
            if (gpos) begin
              ret <= (num > DNW'(RET_MAX)) ? RET_MAX : num[RET_W-1:0];
            end else begin
              ret <= (num >= DNW'(RET_MIN)) ? RET_MIN : -num[RET_W-1:0];
            end
            state <= ST_CLOSE;
          end
        end
        ST_CLOSE: begin
          good <= ($signed(ret) >= $signed(thr));
          if (($signed(ret) >= $signed(thr)) && (pcount != '1)) pcount <= pcount + 1'b1;
          if (tcount != '1) tcount <= tcount + 1'b1;
          rsum <= rs_sat;
          closed <= 1'b1;
          pos <= POS_FLAT;
          state <= cur_last ? ST_TOTALS : ST_OUT;
        end
        ST_TOTALS: begin
          if (tcount == '0) begin
            state <= ST_OUT;
          end else begin
            rem <= '0;
            num <= DNW'({p100, {FRAC_BITS{1'b0}}});
            den <= DW'(tcount);
            cnt <= CW'(DNW);
            state <= ST_DIV_PCT;
          end
        end
        ST_DIV_PCT: begin
          if (cnt != '0) begin
            rem <= qbit ? add_full[DW-1:0] : add_x[DW-1:0];
            num <= {num[DNW-2:0], qbit};
            cnt <= cnt - 1'b1;
          end else begin
            pct <= num[PCT_W-1:0];
            gpos <= !rsum[AVG_W-1];
            rem <= '0;
            num <= r100;
            den <= DW'(tcount);
            cnt <= CW'(DNW);
            state <= ST_DIV_AVG;
          end
        end
        ST_DIV_AVG: begin
          if (cnt != '0) begin
            rem <= qbit ? add_full[DW-1:0] : add_x[DW-1:0];
            num <= {num[DNW-2:0], qbit};
            cnt <= cnt - 1'b1;
          end else begin
            if (gpos) begin
              avg <= (num > DNW'(AVG_MAX)) ? AVG_MAX : num[AVG_W-1:0];
            end else begin
              avg <= (num > DNW'(AVG_MIN)) ? AVG_MIN : -num[AVG_W-1:0];
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tlast <= cur_last;
            m_tdata <= {{(OUT_W - OUT_FIELDS_W){1'b0}}, avg, pct,
                        cur_last ? tcount : {CNT_W{1'b0}}, good, ret, closed, sig};
            if (cur_last) begin
              for (int i = 0; i < N; i++) win[i] <= '0;
              ptr <= '0;
              seen <= '0;
              wsum <= '0;
              qsum <= '0;
              pos <= POS_FLAT;
              entry <= '0;
              tcount <= '0;
              pcount <= '0;
              rsum <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `BBST_ASSERT_NEXT(busy_after_accept, s_tvalid && s_tready, !s_tready)
  `BBST_ASSERT_NOW(result_from_out_state, $rose(m_tvalid), $past(state) == ST_OUT)
  `BBST_ASSERT_NOW(profitable_within_total, 1'b1, pcount <= tcount)

endmodule
